FILE: sv/cus_pkg.sv
package cus_pkg;

    // Probability and score formats
    localparam int PROB_W      = 17;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
    localparam int SCORE_W     = 20;
    localparam logic [SCORE_W-1:0] SUM_MAX = 20'hFFFFF;

    // Log unit: Q1.62 mantissa, one result bit per squaring step
    localparam int MANT_W      = 63;
    localparam int MANT_TOP    = 62;
    localparam int FRAC_BITS   = 40;
    localparam int LOG_STEPS   = FRAC_BITS;
    localparam int SHIFT_W     = 5;
    localparam int INT_BITS    = 16;
    localparam int V_W         = SHIFT_W + FRAC_BITS;
    localparam int LOG_W       = V_W - (FRAC_BITS - 16);
    localparam int PROD_W      = PROB_W + LOG_W;
    localparam int TERM_W      = PROD_W - 16;

    // Queue between front and back
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    // Stream and register port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_LEAST_CONF = 2'd0,
        MODE_MARGIN     = 2'd1,
        MODE_ENTROPY    = 2'd2
    } mode_t;

    // One classified beat as it waits in the queue
    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              last;
        mode_t             mode;
        logic [PROB_W-1:0] alt_score;
    } item_t;

    // Payload carried alongside the log pipeline
    typedef struct packed {
        logic [PROB_W-1:0]  prob;
        logic [SHIFT_W-1:0] msb;
        logic               last;
        mode_t              mode;
        logic [PROB_W-1:0]  alt_score;
    } side_t;

    // Index of the highest set bit, zero for a zero input
    function automatic logic [SHIFT_W-1:0] msb_index(input logic [PROB_W-1:0] p);
        logic [SHIFT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < PROB_W; i++)
        begin
            if (p[i])
            begin
                idx = SHIFT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/cus_front.sv
module cus_front
    import cus_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    // Input stream
    input  logic                   s_axis_tvalid,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] class_probability
    input  logic                   s_axis_tlast,   // last_class
    input  logic                   q_ready,
    output logic                   q_push,
    output item_t                  q_item
);

    mode_t             mode_reg;
    logic [PROB_W-1:0] top_reg;
    logic [PROB_W-1:0] run_reg;
    logic [PROB_W-1:0] top_next;
    logic [PROB_W-1:0] run_next;
    logic [PROB_W-1:0] prob;
    logic [PROB_W-1:0] alt_score;
    logic              cfg_wr;

    // Decode register writes and reads
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[ADDR_W-1:2] == REG_MODE) ? DATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENTROPY;
        end
        else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_MODE))
        begin
            mode_reg <= mode_t'(pwdata[1:0]);
        end
    end

    // Clamp the probability and track the top two
    always_comb
    begin
        prob = (s_axis_tdata[PROB_W-1:0] > ONE_Q16) ? ONE_Q16 : s_axis_tdata[PROB_W-1:0];
        top_next = top_reg;
        run_next = run_reg;
        if (prob > top_reg)
        begin
            top_next = prob;
            run_next = top_reg;
        end
        else if (prob > run_reg)
        begin
            run_next = prob;
        end
        case (mode_reg)
            MODE_LEAST_CONF: alt_score = ONE_Q16 - top_next;
            MODE_MARGIN:     alt_score = ONE_Q16 - (top_next - run_next);
            default:         alt_score = '0;
        endcase
    end

    assign q_push           = s_axis_tvalid && q_ready;
    assign q_item.prob      = prob;
    assign q_item.last      = s_axis_tlast;
    assign q_item.mode      = mode_reg;
    assign q_item.alt_score = alt_score;

    // Advance the top-two state, clear it after the final beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            run_reg <= '0;
        end
        else if (q_push)
        begin
            if (s_axis_tlast)
            begin
                top_reg <= '0;
                run_reg <= '0;
            end
            else
            begin
                top_reg <= top_next;
                run_reg <= run_next;
            end
        end
    end

    a_order: assert property (@(posedge clk) disable iff (!rst_n) run_reg <= top_reg)
        else $error("runner-up above top probability");
    a_range: assert property (@(posedge clk) disable iff (!rst_n) top_reg <= ONE_Q16)
        else $error("top probability above one");

endmodule

FILE: sv/cus_fifo.sv
module cus_fifo
    import cus_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t din,
    output logic  ready,
    input  logic  pop,
    output item_t dout,
    output logic  empty
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    assign ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue overfilled");

endmodule

FILE: sv/cus_log_step.sv
module cus_log_step
    import cus_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [MANT_W-1:0]    m_in,
    input  logic [FRAC_BITS-1:0] f_in,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic [MANT_W-1:0]    m_out,
    output logic [FRAC_BITS-1:0] f_out,
    output side_t                side_out
);

    logic                 a_valid_reg;
    logic [63:0]          pp0_reg;
    logic [62:0]          pp1_reg;
    logic [61:0]          pp2_reg;
    logic [FRAC_BITS-1:0] a_f_reg;
    side_t                a_side_reg;
    logic [125:0]         full_sq;
    logic [63:0]          sq;
    logic                 b_valid_reg;
    logic [MANT_W-1:0]    m_reg;
    logic [FRAC_BITS-1:0] f_reg;
    side_t                b_side_reg;

    // Partial products of the squared mantissa
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_reg    <= 64'(m_in[31:0]) * 64'(m_in[31:0]);
            pp1_reg    <= 63'(m_in[62:32]) * 63'(m_in[31:0]);
            pp2_reg    <= 62'(m_in[62:32]) * 62'(m_in[62:32]);
            a_f_reg    <= f_in;
            a_side_reg <= side_in;
        end
    end

    // Sum partials, keep Q2.62, renormalize and emit one result bit
    assign full_sq = {pp2_reg, 64'b0} + {30'b0, pp1_reg, 33'b0} + {62'b0, pp0_reg};
    assign sq      = full_sq[125:62];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg      <= sq[63] ? sq[63:1] : sq[62:0];
            f_reg      <= {a_f_reg[FRAC_BITS-2:0], sq[63]};
            b_side_reg <= a_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign m_out     = m_reg;
    assign f_out     = f_reg;
    assign side_out  = b_side_reg;

endmodule

FILE: sv/cus_back.sv
module cus_back
    import cus_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [19:0] uncertainty
);

    logic                 adv;
    logic                 p_valid_reg;
    logic [MANT_W-1:0]    p_m_reg;
    side_t                p_side_reg;
    logic [SHIFT_W-1:0]   msb;
    logic                 chain_valid [LOG_STEPS+1];
    logic [MANT_W-1:0]    chain_m     [LOG_STEPS+1];
    logic [FRAC_BITS-1:0] chain_f     [LOG_STEPS+1];
    side_t                chain_side  [LOG_STEPS+1];
    logic [V_W-1:0]       v;
    logic [V_W:0]         v_round;
    logic                 l_valid_reg;
    logic [LOG_W-1:0]     l_reg;
    side_t                l_side_reg;
    logic [PROD_W-1:0]    prod;
    logic                 t_valid_reg;
    logic [TERM_W-1:0]    term_reg;
    side_t                t_side_reg;
    logic [TERM_W:0]      sum_wide;
    logic [SCORE_W-1:0]   sum_sat;
    logic [SCORE_W-1:0]   sum_reg;
    logic [SCORE_W-1:0]   score;
    logic                 out_valid_reg;
    logic [SCORE_W-1:0]   out_data_reg;

    // Whole back end moves when the output register is free
    assign adv   = !out_valid_reg || m_axis_tready;
    assign q_pop = adv && !q_empty;
    assign msb   = msb_index(q_item.prob);

    // Normalize the probability into a Q1.62 mantissa
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_m_reg              <= MANT_W'(q_item.prob) << (SHIFT_W + 1)'(MANT_TOP - int'(msb));
            p_side_reg.prob      <= q_item.prob;
            p_side_reg.msb       <= msb;
            p_side_reg.last      <= q_item.last;
            p_side_reg.mode      <= q_item.mode;
            p_side_reg.alt_score <= q_item.alt_score;
        end
    end

    assign chain_valid[0] = p_valid_reg;
    assign chain_m[0]     = p_m_reg;
    assign chain_f[0]     = '0;
    assign chain_side[0]  = p_side_reg;

    // One squaring step per fraction bit of the logarithm
    for (genvar g = 0; g < LOG_STEPS; g++)
    begin : g_step
        cus_log_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (chain_valid[g]),
            .m_in      (chain_m[g]),
            .f_in      (chain_f[g]),
            .side_in   (chain_side[g]),
            .out_valid (chain_valid[g+1]),
            .m_out     (chain_m[g+1]),
            .f_out     (chain_f[g+1]),
            .side_out  (chain_side[g+1])
        );
    end

    // Form the rounded negative log in Q16
    assign v       = {SHIFT_W'(INT_BITS) - chain_side[LOG_STEPS].msb, FRAC_BITS'(0)}
                   - V_W'(chain_f[LOG_STEPS]);
    assign v_round = (V_W + 1)'(v) + ((V_W + 1)'(1) << (FRAC_BITS - 17));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_reg      <= v_round[FRAC_BITS-16 +: LOG_W];
            l_side_reg <= chain_side[LOG_STEPS];
        end
    end

    // Entropy term, zero probability gives a zero product
    assign prod = PROD_W'(l_side_reg.prob) * PROD_W'(l_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg   <= prod[PROD_W-1:16];
            t_side_reg <= l_side_reg;
        end
    end

    // Saturating accumulate and score select
    assign sum_wide = (TERM_W + 1)'(sum_reg) + (TERM_W + 1)'(term_reg);
    assign sum_sat  = (sum_wide > (TERM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SCORE_W-1:0];

    always_comb
    begin
        case (t_side_reg.mode)
            MODE_ENTROPY: score = sum_sat;
            default:      score = SCORE_W'(t_side_reg.alt_score);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv && t_valid_reg && t_side_reg.last)
        begin
            out_data_reg <= score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            l_valid_reg   <= 1'b0;
            t_valid_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg   <= !q_empty;
            l_valid_reg   <= chain_valid[LOG_STEPS];
            t_valid_reg   <= l_valid_reg;
            out_valid_reg <= t_valid_reg && t_side_reg.last;
            if (t_valid_reg)
            begin
                sum_reg <= t_side_reg.last ? '0 : sum_sat;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> ($stable(t_valid_reg) && $stable(sum_reg)))
        else $error("back end moved while output stalled");

endmodule

FILE: sv/classifier_uncertainty_score_unit.sv
// Uncertainty score of one classifier output vector.
// Input stream: one class probability per beat on s_axis_tdata[16:0], unsigned
// Q0.16 (65536 is 1.0, larger values count as 1.0); s_axis_tlast marks the final
// class of the vector. Output stream: one beat per vector on m_axis_tdata[19:0],
// the score in unsigned Q4.16.
// APB register 0 (address 0) selects the score: 0 least confidence, 1 margin
// between the top two, 2 entropy (saturating sum), 3 gives zero. Write it only
// while no vector is in flight.
// Throughput: one beat per cycle. The front end tracks the top two values and
// pushes into a four-entry queue; the back end computes -log2(p) with a 40-step
// squaring pipeline, two registers per step, then the term and the accumulator.
// The score goes valid in the output register, which follows the term register.
// A stalled receiver freezes the back end; the queue keeps taking beats until
// it fills, then s_axis_tready drops.
// Reset selects entropy mode and clears the top two, the sum and all valids.
module classifier_uncertainty_score_unit
    import cus_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] class_probability
    input  logic                   s_axis_tlast,   // last_class
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [19:0] uncertainty
);

    logic  q_ready;
    logic  q_push;
    logic  q_pop;
    logic  q_empty;
    item_t q_in;
    item_t q_out;

    assign pready        = 1'b1;
    assign s_axis_tready = q_ready;

    cus_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    cus_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .ready (q_ready),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    cus_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
